// ===== src/cts_pkg.sv =====
// Shared types, constants and helpers of the calculator token scanner.
package cts_pkg;

  localparam int unsigned DefMaxTokenLen = 128;
  localparam int unsigned DefQueueDepth  = 4;
  localparam int unsigned LenW           = 8;
  localparam int unsigned CharW          = 8;
  localparam int unsigned OutDataW       = 16;

  typedef enum logic [3:0] {
    KIND_READ    = 4'd0,
    KIND_WRITE   = 4'd1,
    KIND_ID      = 4'd2,
    KIND_LIT     = 4'd3,
    KIND_GETS    = 4'd4,
    KIND_ADD     = 4'd5,
    KIND_SUB     = 4'd6,
    KIND_MUL     = 4'd7,
    KIND_DIV     = 4'd8,
    KIND_LPAREN  = 4'd9,
    KIND_RPAREN  = 4'd10,
    KIND_EQ      = 4'd11,
    KIND_LESS    = 4'd12,
    KIND_GREATER = 4'd13,
    KIND_EOF     = 4'd14,
    KIND_ERROR   = 4'd15
  } kind_e;

  typedef struct packed {
    kind_e           kind;
    logic [LenW-1:0] length;
    logic            overflow;
  } tok_t;

  // One queue entry: every result that one accepted character causes.
  // The second token, when present, always has zero length and no overflow.
  typedef struct packed {
    logic  two;
    tok_t  first;
    kind_e second_kind;
  } rec_t;

  localparam logic [CharW-1:0] ChUnderscore = 8'h5f;
  localparam logic [CharW-1:0] ChColon      = 8'h3a;
  localparam logic [CharW-1:0] ChEquals     = 8'h3d;

  // Letter of "read" at a position; zero past the end.
  function automatic logic [CharW-1:0] kw_read_char(input logic [LenW-1:0] pos);
    logic [CharW-1:0] ch;
    unique case (pos)
      8'd0:    ch = 8'h72;
      8'd1:    ch = 8'h65;
      8'd2:    ch = 8'h61;
      8'd3:    ch = 8'h64;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Letter of "write" at a position; zero past the end.
  function automatic logic [CharW-1:0] kw_write_char(input logic [LenW-1:0] pos);
    logic [CharW-1:0] ch;
    unique case (pos)
      8'd0:    ch = 8'h77;
      8'd1:    ch = 8'h72;
      8'd2:    ch = 8'h69;
      8'd3:    ch = 8'h74;
      8'd4:    ch = 8'h65;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== src/cts_front.sv =====
// Front end: accepts characters, tracks the scan mode and builds token records.
module cts_front import cts_pkg::*; #(
  parameter int unsigned MAX_TOKEN_LEN = DefMaxTokenLen
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [CharW-1:0] char_i,
  input  logic             eoi_i,
  output logic             push_o,
  output rec_t             rec_o
);

  localparam logic [LenW-1:0] MaxLen = LenW'(MAX_TOKEN_LEN);

  typedef enum logic [4:0] {
    MODE_IDLE  = 5'b00001,
    MODE_IDENT = 5'b00010,
    MODE_LIT   = 5'b00100,
    MODE_COLON = 5'b01000,
    MODE_HALT  = 5'b10000
  } mode_e;

  mode_e           mode_q, mode_d;
  logic [LenW-1:0] len_q, len_d;
  logic            read_q, read_d;
  logic            write_q, write_d;
  logic            ovf_q, ovf_d;

  logic  is_alpha, is_digit, is_space;
  logic  op_valid;
  kind_e op_kind;
  logic  cont;
  kind_e run_kind;

  assign is_alpha = (char_i >= 8'h61 && char_i <= 8'h7a) || (char_i >= 8'h41 && char_i <= 8'h5a);
  assign is_digit = char_i >= 8'h30 && char_i <= 8'h39;
  assign is_space = char_i == 8'h20 || (char_i >= 8'h09 && char_i <= 8'h0d);

  // Single-character operators; anything else that is not handled is illegal.
  always_comb begin
    op_valid = 1'b1;
    unique case (char_i)
      8'h2b:   op_kind = KIND_ADD;
      8'h2d:   op_kind = KIND_SUB;
      8'h2a:   op_kind = KIND_MUL;
      8'h2f:   op_kind = KIND_DIV;
      8'h28:   op_kind = KIND_LPAREN;
      8'h29:   op_kind = KIND_RPAREN;
      8'h3d:   op_kind = KIND_EQ;
      8'h3c:   op_kind = KIND_LESS;
      8'h3e:   op_kind = KIND_GREATER;
      default: begin
        op_kind  = KIND_ERROR;
        op_valid = 1'b0;
      end
    endcase
  end

  assign cont = !eoi_i && ((mode_q == MODE_IDENT)
                           ? (is_alpha || is_digit || char_i == ChUnderscore)
                           : is_digit);

  always_comb begin
    if (mode_q == MODE_IDENT) begin
      if (read_q && len_q == 8'd4) begin
        run_kind = KIND_READ;
      end else if (write_q && len_q == 8'd5) begin
        run_kind = KIND_WRITE;
      end else begin
        run_kind = KIND_ID;
      end
    end else begin
      run_kind = KIND_LIT;
    end
  end

  always_comb begin
    logic  idle_emit;
    kind_e idle_kind;
    mode_d  = mode_q;
    len_d   = len_q;
    read_d  = read_q;
    write_d = write_q;
    ovf_d   = ovf_q;
    push_o  = 1'b0;
    rec_o   = '{two: 1'b0,
                first: '{kind: KIND_EOF, length: '0, overflow: 1'b0},
                second_kind: KIND_EOF};
    idle_emit = 1'b0;
    idle_kind = op_kind;

    // Shared handling of a character seen while idle (no result by itself
    // for whitespace, run starts and a colon).
    if (accept_i && !eoi_i && (mode_q == MODE_IDLE || ((mode_q == MODE_IDENT ||
        mode_q == MODE_LIT) && !cont))) begin
      priority if (is_space) begin
        mode_d = MODE_IDLE;
      end else if (is_alpha || is_digit) begin
        mode_d  = is_alpha ? MODE_IDENT : MODE_LIT;
        len_d   = 8'd1;
        ovf_d   = 1'b0;
        read_d  = is_alpha && char_i == kw_read_char(8'd0);
        write_d = is_alpha && char_i == kw_write_char(8'd0);
      end else if (char_i == ChColon) begin
        mode_d = MODE_COLON;
      end else begin
        idle_emit = 1'b1;
        mode_d    = op_valid ? MODE_IDLE : MODE_HALT;
      end
    end

    if (accept_i) begin
      unique case (mode_q)
        MODE_HALT: begin
          mode_d = MODE_HALT;
        end
        MODE_COLON: begin
          push_o = 1'b1;
          if (!eoi_i && char_i == ChEquals) begin
            rec_o.first.kind = KIND_GETS;
            mode_d           = MODE_IDLE;
          end else begin
            rec_o.first.kind = KIND_ERROR;
            mode_d           = MODE_HALT;
          end
        end
        MODE_IDENT, MODE_LIT: begin
          if (cont) begin
            read_d  = read_q && len_q < 8'd4 && char_i == kw_read_char(len_q);
            write_d = write_q && len_q < 8'd5 && char_i == kw_write_char(len_q);
            if (len_q >= MaxLen) begin
              ovf_d = 1'b1;
            end else begin
              len_d = len_q + 8'd1;
            end
          end else begin
            push_o         = 1'b1;
            rec_o.first    = '{kind: run_kind, length: len_q, overflow: ovf_q};
            if (eoi_i) begin
              mode_d            = MODE_IDLE;
              rec_o.two         = 1'b1;
              rec_o.second_kind = KIND_EOF;
            end else begin
              rec_o.two         = idle_emit;
              rec_o.second_kind = idle_kind;
            end
          end
        end
        MODE_IDLE: begin
          if (eoi_i) begin
            push_o = 1'b1;
          end else begin
            push_o           = idle_emit;
            rec_o.first.kind = idle_kind;
          end
        end
        default: begin
          mode_d = MODE_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      len_q   <= '0;
      read_q  <= 1'b0;
      write_q <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      len_q   <= len_d;
      read_q  <= read_d;
      write_q <= write_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

// ===== src/cts_queue.sv =====
// Short record queue between the scanner front end and the output side.
module cts_queue import cts_pkg::*; #(
  parameter int unsigned DEPTH = DefQueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  rec_t push_rec_i,
  input  logic pop_i,
  output rec_t pop_rec_o,
  output logic full_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  rec_t            entries_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o    = count_q == FullCnt;
  assign empty_o   = count_q == '0;
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign pop_rec_o = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== src/cts_back.sv =====
// Back end: unpacks queued records into single tokens on a registered output.
module cts_back import cts_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  rec_t rec_i,
  input  logic rec_valid_i,
  output logic pop_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output tok_t out_tok_o,
  output logic out_last_o
);

  logic  out_valid_q, out_valid_d;
  tok_t  out_tok_q, out_tok_d;
  logic  out_last_q, out_last_d;
  logic  pend_q, pend_d;
  kind_e pend_kind_q, pend_kind_d;
  logic  load;

  assign load = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_tok_d   = out_tok_q;
    out_last_d  = out_last_q;
    pend_d      = pend_q;
    pend_kind_d = pend_kind_q;
    pop_o       = 1'b0;
    if (load) begin
      priority if (pend_q) begin
        // Second token of the held record closes the group.
        out_valid_d = 1'b1;
        out_tok_d   = '{kind: pend_kind_q, length: '0, overflow: 1'b0};
        out_last_d  = 1'b1;
        pend_d      = 1'b0;
      end else if (rec_valid_i) begin
        pop_o       = 1'b1;
        out_valid_d = 1'b1;
        out_tok_d   = rec_i.first;
        out_last_d  = !rec_i.two;
        pend_d      = rec_i.two;
        pend_kind_d = rec_i.second_kind;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_tok_q   <= out_tok_d;
    out_last_q  <= out_last_d;
    pend_kind_q <= pend_kind_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_tok_o   = out_tok_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== src/calculator_token_scanner.sv =====
// Top level of the calculator token scanner.
//
// Streaming token scanner for the small calculator language. One character
// (or, with s_axis_tuser high, an end-of-input mark) enters per transfer, and
// a character is taken in every cycle as long as the internal record queue
// has room. The front end updates the scan state in the same cycle and queues
// one record per character that finishes something; the back end turns each
// record into one or two token transfers on the master side, one per cycle
// while m_axis_tready is high, through an output register. A character that
// ends an identifier or literal and is itself an operator produces two
// tokens, so the sustained rate is one character per cycle limited only by
// the output side draining at one token per cycle. Each record is written
// into the queue and then loaded into the output register. Whitespace is
// dropped; identifiers and literals report their length, saturated at
// MAX_TOKEN_LEN with length_overflow set when it was exceeded; "read" and
// "write" come out as keywords. An illegal character or a colon not followed
// by '=' yields an error token, after which all input is absorbed with no
// output until reset. m_axis_tlast marks the final token caused by one input.
module calculator_token_scanner import cts_pkg::*; #(
  parameter int unsigned MAX_TOKEN_LEN = DefMaxTokenLen,
  parameter int unsigned QUEUE_DEPTH   = DefQueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [CharW-1:0]    s_axis_tdata,   // [7:0] char_code
  input  logic                s_axis_tuser,   // [0] end_of_input
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [3:0] token_kind, [11:4] token_length,
                                              // [12] length_overflow, [15:13] zero
  output logic                m_axis_tlast    // last_result
);

  logic accept;
  logic push;
  rec_t push_rec;
  rec_t pop_rec;
  logic pop;
  logic full, empty;
  tok_t out_tok;

  // Take a character whenever the queue can hold its record.
  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  cts_front #(
    .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .char_i  (s_axis_tdata),
    .eoi_i   (s_axis_tuser),
    .push_o  (push),
    .rec_o   (push_rec)
  );

  cts_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_rec_i(push_rec),
    .pop_i     (pop),
    .pop_rec_o (pop_rec),
    .full_o    (full),
    .empty_o   (empty)
  );

  cts_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rec_i      (pop_rec),
    .rec_valid_i(!empty),
    .pop_o      (pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_tok_o  (out_tok),
    .out_last_o (m_axis_tlast)
  );

  // Pack the token fields, lowest field first, zero padding on top.
  assign m_axis_tdata = {3'b000, out_tok.overflow, out_tok.length, out_tok.kind};

endmodule
